// ===== rtl/core/cddi_pkg.sv =====
package cddi_pkg;

  localparam int HASH_W       = 32;
  localparam int HASH_SHIFT   = 5;
  localparam int POS_W        = 32;
  localparam int DIG_W        = 64;
  // Remainder unit: reciprocal multiply, back-multiply and subtract, final correction.
  localparam int MOD_CYCLES   = 3;
  localparam int MOD_CNT_W    = $clog2(MOD_CYCLES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH_HI,
    ST_HASH_LO,
    ST_MOD,
    ST_READ,
    ST_DECIDE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic hash_hi;
    logic hash_lo;
    logic mod_step;
    logic rd;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } sts_t;

  typedef struct packed {
    logic [DIG_W-1:0] hi;
    logic [DIG_W-1:0] lo;
    logic [POS_W-1:0] pos;
  } way_t;

  // Times-33 hash over the eight bytes of one digest half, most significant byte first.
  function automatic logic [HASH_W-1:0] mix_half(input logic [HASH_W-1:0] h_in,
                                                 input logic [DIG_W-1:0] half);
    logic [HASH_W-1:0] h;
    h = h_in;
    for (int k = 7; k >= 0; k--) begin
      h = (h << HASH_SHIFT) + h + {24'd0, half[k*8 +: 8]};
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/chunk_digest_dedup_index_top.sv =====
// Deduplication index for 128-bit chunk digests.
// Input channel: in_valid/in_ready carry one digest per transaction as two 64-bit
// halves. Result channel: out_valid/out_ready carry one result per input transaction:
// a duplicate flag, the 1-based chunk position (of the first occurrence on a hit)
// and a flag raised when the digest's bucket had no free way to store it in.
// Each transaction walks a fixed sequence: times-33 hashing of the high and then the low
// half, the remainder-unit steps (reciprocal multiply, back-multiply and subtract,
// final correction), one bucket-row read and one compare/write-back step. A new
// transaction is taken only after the write-back of the last one, since the sequencer
// returns to idle only then.
// Reset clears the chunk counter and the output valid, then a clearing pass writes
// the valid bits of every bucket row, one row per cycle, for all BUCKETS rows
// (256 by default); in_ready stays low during that pass.
// When the receiver stalls, the finished result waits in the output register and
// the next transaction may already be accepted and processed; its write-back waits
// until the pending result has been taken.
module chunk_digest_dedup_index_top #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_digest_high,
  input  logic [63:0] in_digest_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_duplicate,
  output logic [31:0] out_chunk_number,
  output logic        out_bucket_full
);
  import cddi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the handshakes and steps the datapath.
  cddi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hash, remainder unit, bucket memory, way compare and result register.
  cddi_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_digest_high   (in_digest_high),
    .in_digest_low    (in_digest_low),
    .cmd              (cmd),
    .sts              (sts),
    .out_is_duplicate (out_is_duplicate),
    .out_chunk_number (out_chunk_number),
    .out_bucket_full  (out_bucket_full)
  );

endmodule

// ===== rtl/core/cddi_ctrl.sv =====
module cddi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cddi_pkg::sts_t sts,
  output cddi_pkg::cmd_t cmd
);
  import cddi_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = ST_HASH_HI;
      ST_HASH_HI: state_nxt = ST_HASH_LO;
      ST_HASH_LO: state_nxt = ST_MOD;
      ST_MOD:     if (sts.mod_last) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_DECIDE;
      ST_DECIDE:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:   cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_HASH_HI: cmd.hash_hi = 1'b1;
      ST_HASH_LO: cmd.hash_lo = 1'b1;
      ST_MOD:     cmd.mod_step = 1'b1;
      ST_READ:    cmd.rd = 1'b1;
      ST_DECIDE:  cmd.commit = out_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // A result is only committed when the output register is free.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while output register occupied");

  // A committed result is presented in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // No transaction is taken while the table is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("input taken during clearing pass");

  // The remainder unit runs until its last step.
  a_mod_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD && !sts.mod_last) |=> state_r == ST_MOD)
    else $error("remainder unit left early");

endmodule

// ===== rtl/core/cddi_datapath.sv =====
module cddi_datapath #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [63:0]   in_digest_high,
  input  logic [63:0]   in_digest_low,
  input  cddi_pkg::cmd_t cmd,
  output cddi_pkg::sts_t sts,
  output logic          out_is_duplicate,
  output logic [31:0]   out_chunk_number,
  output logic          out_bucket_full
);
  import cddi_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW-1:0]    LAST_BKT = BW'(BUCKETS - 1);
  localparam logic [HASH_W-1:0] BKT_H   = HASH_W'(BUCKETS);
  // Floor of 2^32 over the bucket count; the quotient estimate is exact or one low.
  localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / 64'(BUCKETS));
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_CYCLES - 1);

  logic [DIG_W-1:0]     dig_hi_r, dig_lo_r;
  logic [HASH_W-1:0]    hash_r;
  logic [2*HASH_W-1:0]  prod_r, prod_nxt;
  logic [HASH_W-1:0]    rest_r, rest_nxt;
  logic [HASH_W-1:0]    rem_full;
  logic [BW-1:0]        rem_r;
  logic [MOD_CNT_W-1:0] mod_cnt_r;
  logic [BW-1:0]        clr_cnt_r;
  logic [POS_W-1:0]     chunks_seen_r, pos;

  way_t [WAYS-1:0]      row_mem [BUCKETS];
  logic [WAYS-1:0]      vld_mem [BUCKETS];
  way_t [WAYS-1:0]      rd_row_r;
  logic [WAYS-1:0]      rd_vld_r;

  logic [WAYS-1:0]      hit_vec, hit_oh, free_vec, free_oh;
  logic                 hit, have_free, wr_en;
  logic [POS_W-1:0]     hit_pos;
  way_t [WAYS-1:0]      new_row;
  logic [WAYS-1:0]      new_vld;

  logic                 out_is_duplicate_r;
  logic [POS_W-1:0]     out_chunk_number_r;
  logic                 out_bucket_full_r;

  // Digest capture, hashing and the remainder pipeline.
  // The hash holds still during the remainder steps, so after three steps every
  // stage has seen correct inputs and rem_r holds the bucket index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dig_hi_r <= in_digest_high;
      dig_lo_r <= in_digest_low;
    end
    if (cmd.hash_hi) begin
      hash_r <= mix_half('0, dig_hi_r);
    end else if (cmd.hash_lo) begin
      hash_r <= mix_half(hash_r, dig_lo_r);
    end
    if (cmd.mod_step) begin
      prod_r <= prod_nxt;
      rest_r <= rest_nxt;
      rem_r  <= rem_full[BW-1:0];
    end
  end

  // Remainder by the bucket count through reciprocal multiplication.
  always_comb begin
    prod_nxt = {{HASH_W{1'b0}}, hash_r} * {{HASH_W{1'b0}}, RECIP};
    rest_nxt = hash_r - prod_r[2*HASH_W-1:HASH_W] * BKT_H;
    rem_full = (rest_r >= BKT_H) ? rest_r - BKT_H : rest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r     <= '0;
      clr_cnt_r     <= '0;
      chunks_seen_r <= '0;
    end else begin
      if (cmd.hash_lo) begin
        mod_cnt_r <= '0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 1'b1;
      end
      if (cmd.clear_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        chunks_seen_r <= pos;
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == LAST_BKT);
  assign sts.mod_last = (mod_cnt_r == MOD_LAST);

  assign pos = (chunks_seen_r == '1) ? chunks_seen_r : chunks_seen_r + 1'b1;

  // Bucket memory: one row holds all ways of a bucket.
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      vld_mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      vld_mem[rem_r] <= new_vld;
      row_mem[rem_r] <= new_row;
    end
    if (cmd.rd) begin
      rd_vld_r <= vld_mem[rem_r];
      rd_row_r <= row_mem[rem_r];
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_vld_r[w] && (rd_row_r[w].hi == dig_hi_r) && (rd_row_r[w].lo == dig_lo_r);
      free_vec[w] = !rd_vld_r[w];
    end
  end

  assign hit_oh    = hit_vec & (~hit_vec + 1'b1);
  assign free_oh   = free_vec & (~free_vec + 1'b1);
  assign hit       = |hit_vec;
  assign have_free = |free_vec;
  assign wr_en     = cmd.commit && !hit && have_free;
  assign new_vld   = rd_vld_r | free_oh;

  always_comb begin
    hit_pos = '0;
    new_row = rd_row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_pos = hit_pos | rd_row_r[w].pos;
      end
      if (free_oh[w]) begin
        new_row[w].hi  = dig_hi_r;
        new_row[w].lo  = dig_lo_r;
        new_row[w].pos = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_is_duplicate_r <= hit;
      out_chunk_number_r <= hit ? hit_pos : pos;
      out_bucket_full_r  <= !hit && !have_free;
    end
  end

  assign out_is_duplicate = out_is_duplicate_r;
  assign out_chunk_number = out_chunk_number_r;
  assign out_bucket_full  = out_bucket_full_r;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cddi_pkg::DIG_W;
  import cddi_pkg::POS_W;

  // Table geometry used for the instance below. The aimed-digest generator relies
  // on BUCKETS being a power of two no larger than 256.
  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int TOTAL_DIGESTS = 1650;
  // The slowest correct transaction is its own work, the longest sender gap and the
  // longest receiver stall from pick_gap. The reset clearing pass comes on top of that.
  localparam int CYCLE_LIMIT = 800_000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOT_BUCKETS = 12;

  // One result as the index reports it.
  typedef struct {
    logic             dup;
    logic [POS_W-1:0] number;
    logic             full;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [DIG_W-1:0] in_digest_high;
  logic [DIG_W-1:0] in_digest_low;
  logic             out_valid;
  logic             out_ready;
  logic             out_is_duplicate;
  logic [POS_W-1:0] out_chunk_number;
  logic             out_bucket_full;

  chunk_digest_dedup_index_top #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_digest_high  (in_digest_high),
    .in_digest_low   (in_digest_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_duplicate(out_is_duplicate),
    .out_chunk_number(out_chunk_number),
    .out_bucket_full (out_bucket_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the index: one entry per way, plus the running chunk count.
  bit               way_used [SLOTS];
  logic [DIG_W-1:0] way_high [SLOTS];
  logic [DIG_W-1:0] way_low  [SLOTS];
  logic [POS_W-1:0] way_pos  [SLOTS];
  logic [POS_W-1:0] chunks_tallied;

  verdict_t pending_verdicts[$];
  logic [2*DIG_W-1:0] sent_digests[$];

  int errors;
  int cycle_count;
  int first_stores;
  int repeat_hits;
  int overflow_rejects;

  // When steady is set, neither side idles, so back-to-back transactions occur.
  bit steady;
  int ready_hold;

  // Raw times-33 sum over the 16 digest bytes, byte 15 (the top of the high half)
  // first, kept to 32 bits.
  function automatic logic [31:0] digest_sum(input logic [2*DIG_W-1:0] digest);
    logic [31:0] acc;
    acc = '0;
    for (int i = 15; i >= 0; i--) begin
      acc = acc * 32'd33 + 32'(digest[i*8 +: 8]);
    end
    return acc;
  endfunction

  function automatic int bucket_of(input logic [2*DIG_W-1:0] digest);
    return int'(digest_sum(digest) % BUCKETS);
  endfunction

  // Random digest that lands in the given bucket. The last byte enters the sum
  // with weight one, so it alone steers the bucket once the rest is fixed.
  function automatic logic [2*DIG_W-1:0] aimed_digest(input int target);
    logic [2*DIG_W-1:0] digest;
    int partial;
    digest = {$urandom, $urandom, $urandom, $urandom};
    digest[7:0] = 8'd0;
    partial = int'(digest_sum(digest) % BUCKETS);
    digest[7:0] = 8'((target - partial + BUCKETS) % BUCKETS);
    return digest;
  endfunction

  // Advances the chunk count, then looks the digest up in its bucket, storing it
  // in the lowest free way on a miss if the bucket has one.
  function automatic verdict_t index_digest(input logic [DIG_W-1:0] high,
                                            input logic [DIG_W-1:0] low);
    verdict_t v;
    int base;
    int free_slot;
    bit found;
    if (chunks_tallied != '1) begin
      chunks_tallied++;
    end
    base = bucket_of({high, low}) * WAYS;
    free_slot = -1;
    found = 1'b0;
    v.dup = 1'b0;
    v.number = chunks_tallied;
    v.full = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (way_used[base + w]) begin
        if (!found && way_high[base + w] == high && way_low[base + w] == low) begin
          found = 1'b1;
          v.dup = 1'b1;
          v.number = way_pos[base + w];
        end
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    if (found) begin
      repeat_hits++;
    end else if (free_slot >= 0) begin
      way_used[free_slot] = 1'b1;
      way_high[free_slot] = high;
      way_low[free_slot] = low;
      way_pos[free_slot] = chunks_tallied;
      first_stores++;
    end else begin
      v.full = 1'b1;
      overflow_rejects++;
    end
    return v;
  endfunction

  // Mostly short gaps, now and then a long one; none while steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(40, 20);
  endfunction

  // Receiver side: out_ready is held at each chosen level for a random stretch.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady || $urandom_range(99) < 65) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(8, 1);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Result checking comes first so that an expectation pushed at this edge can
  // never answer a result seen at the same edge.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("Result with no transaction waiting for it: dup %0d, chunk %0d, full %0d",
               out_is_duplicate, out_chunk_number, out_bucket_full);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_is_duplicate !== want.dup) begin
          $error("is_duplicate: expected %0d, actual %0d", want.dup, out_is_duplicate);
          errors++;
        end
        if (out_chunk_number !== want.number) begin
          $error("chunk_number: expected %0d, actual %0d", want.number, out_chunk_number);
          errors++;
        end
        if (out_bucket_full !== want.full) begin
          $error("bucket_full: expected %0d, actual %0d", want.full, out_bucket_full);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      pending_verdicts.push_back(index_digest(in_digest_high, in_digest_low));
    end
  end

  // Watchdog for a hung handshake on either side.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_verdicts.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one digest and returns at the edge where the transaction is taken.
  // in_valid stays high into the next call unless that call opens a gap.
  task automatic send_digest(input logic [DIG_W-1:0] high, input logic [DIG_W-1:0] low);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_digest_high <= high;
    in_digest_low <= low;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent_digests.push_back({high, low});
  endtask

  // Positions start at one; the all-zero and all-one digests come back as
  // duplicates carrying their first positions.
  task automatic test_chunk_positions();
    send_digest('0, '0);
    send_digest('1, '1);
    send_digest('0, '0);
    send_digest('1, '1);
    send_digest({(DIG_W/2){2'b10}}, {(DIG_W/2){2'b01}});
  endtask

  // Fills the top bucket to the last way and past it, hits every way, then
  // offers the rejected digest again. The all-zero digest already sits in
  // bucket zero, so four more there end in one more rejection.
  task automatic test_bucket_overflow();
    logic [2*DIG_W-1:0] crowd[WAYS + 1];
    logic [2*DIG_W-1:0] digest;
    for (int i = 0; i <= WAYS; i++) begin
      crowd[i] = aimed_digest(BUCKETS - 1);
      send_digest(crowd[i][2*DIG_W-1:DIG_W], crowd[i][DIG_W-1:0]);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      send_digest(crowd[i][2*DIG_W-1:DIG_W], crowd[i][DIG_W-1:0]);
    end
    send_digest(crowd[WAYS][2*DIG_W-1:DIG_W], crowd[WAYS][DIG_W-1:0]);
    for (int i = 0; i < WAYS; i++) begin
      digest = aimed_digest(0);
      send_digest(digest[2*DIG_W-1:DIG_W], digest[DIG_W-1:0]);
    end
  endtask

  // Mixed traffic: repeats of earlier digests, new digests crowded into a few
  // hot buckets so that they fill and overflow, and fully random digests.
  // Some segments run without any idling on either side.
  task automatic test_mixed_traffic(input int count);
    int hot[HOT_BUCKETS];
    int r;
    logic [2*DIG_W-1:0] digest;
    for (int i = 0; i < HOT_BUCKETS; i++) begin
      hot[i] = $urandom_range(BUCKETS - 1);
    end
    hot[0] = 0;
    hot[1] = BUCKETS - 1;
    for (int n = 0; n < count; n++) begin
      steady = ((n / 150) % 4 == 2);
      r = $urandom_range(99);
      if (r < 30) begin
        digest = sent_digests[$urandom_range(sent_digests.size() - 1)];
      end else if (r < 65) begin
        digest = aimed_digest(hot[$urandom_range(HOT_BUCKETS - 1)]);
      end else begin
        digest = {$urandom, $urandom, $urandom, $urandom};
      end
      send_digest(digest[2*DIG_W-1:DIG_W], digest[DIG_W-1:0]);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_digest_high <= '0;
    in_digest_low <= '0;
    out_ready <= 1'b0;
    ready_hold = 0;
    steady = 1'b0;
    errors = 0;
    cycle_count = 0;
    first_stores = 0;
    repeat_hits = 0;
    overflow_rejects = 0;
    chunks_tallied = '0;
    foreach (way_used[i]) way_used[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_chunk_positions();
    test_bucket_overflow();
    test_mixed_traffic(TOTAL_DIGESTS - sent_digests.size());

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Indexed %0d digests in %0d cycles under random idling on both sides.",
             sent_digests.size(), cycle_count);
    $display("Of these, %0d were stored new, %0d were duplicates, %0d hit a full bucket.",
             first_stores, repeat_hits, overflow_rejects);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
